// File: hw/rtl/mspt_pkg.sv
package mspt_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned StreamW = 6;
  localparam int unsigned RateW   = 18;
  localparam int unsigned SizeW   = 17;
  localparam int unsigned PosW    = 27;
  localparam int unsigned TicksW  = 10;
  localparam int unsigned FramesW = 15;

  // divider: dividend holds a position (plus rate), divisor holds a limit or the tick rate
  localparam int unsigned DivDW = PosW + 1;
  localparam int unsigned DivVW = PosW;

  localparam int unsigned DefaultStreams = 32;
  localparam int unsigned MaxResults     = 32;
  localparam int unsigned CntW           = $clog2(MaxResults + 1);

  localparam logic [SizeW-1:0]   MaxBufferBytes = SizeW'(65536);
  localparam logic [TicksW-1:0]  TicksReset     = TicksW'(250);
  localparam logic [TicksW-1:0]  TicksMax       = TicksW'(1000);
  localparam logic [FramesW-1:0] FramesMax      = '1;

  typedef enum logic [KindW-1:0] {
    KindPrepare = 3'd0,
    KindStart   = 3'd1,
    KindStop    = 3'd2,
    KindTick    = 3'd3,
    KindQuery   = 3'd4
  } kind_e;

  typedef struct packed {
    logic [RateW-1:0] rate;
    logic [SizeW-1:0] buf_size;
    logic [SizeW-1:0] per_size;
    logic [PosW-1:0]  ppos;
    logic [PosW-1:0]  bpos;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [DivDW-1:0] dividend;
    logic [DivVW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivDW-1:0] quotient;
    logic [DivVW-1:0] remainder;
  } div_rsp_t;

  function automatic logic [TicksW-1:0] eff_ticks(input logic [TicksW-1:0] t);
    logic [TicksW-1:0] r;
    r = t;
    if (t == '0) begin
      r = TicksW'(1);
    end else if (t > TicksMax) begin
      r = TicksMax;
    end
    return r;
  endfunction

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    return (v > MaxBufferBytes) ? MaxBufferBytes : v;
  endfunction

endpackage

// File: hw/rtl/mspt_in_if.sv
interface mspt_in_if;
  logic                         valid;
  logic                         ready;
  logic [mspt_pkg::KindW-1:0]   kind;
  logic [mspt_pkg::StreamW-1:0] stream;
  logic [mspt_pkg::RateW-1:0]   bytes_per_second;
  logic [mspt_pkg::SizeW-1:0]   buffer_bytes;
  logic [mspt_pkg::SizeW-1:0]   period_bytes;

  modport source (
    output valid, kind, stream, bytes_per_second, buffer_bytes, period_bytes,
    input  ready
  );
  modport sink (
    input  valid, kind, stream, bytes_per_second, buffer_bytes, period_bytes,
    output ready
  );
endinterface

// File: hw/rtl/mspt_out_if.sv
interface mspt_out_if;
  logic                          valid;
  logic                          ready;
  logic [mspt_pkg::StreamW-1:0]  stream_out;
  logic                          is_period_event;
  logic [mspt_pkg::FramesW-1:0]  position_frames;
  logic                          last;

  modport source (
    output valid, stream_out, is_period_event, position_frames, last,
    input  ready
  );
  modport sink (
    input  valid, stream_out, is_period_event, position_frames, last,
    output ready
  );
endinterface

// File: hw/rtl/mspt_divider.sv
module mspt_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mspt_pkg::div_req_t req_i,
  output mspt_pkg::div_rsp_t rsp_o
);
  import mspt_pkg::*;

  localparam int unsigned StepW = $clog2(DivDW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DivVW-1:0] rem_q, rem_d;
  logic [DivVW-1:0] dvs_q, dvs_d;
  logic [DivDW-1:0] quo_q, quo_d;
  logic [DivVW:0]   shifted;
  logic             ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_q, quo_q[DivDW-1]};
    ge      = shifted >= {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? DivVW'(shifted - {1'b0, dvs_q}) : shifted[DivVW-1:0];
      quo_d  = {quo_q[DivDW-2:0], ge};
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(DivDW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: hw/rtl/mspt_stream_mem.sv
module mspt_stream_mem #(
  parameter int unsigned STREAMS = mspt_pkg::DefaultStreams,
  parameter int unsigned IdxW    = (STREAMS > 1) ? $clog2(STREAMS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output mspt_pkg::entry_t rd_data_o,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  mspt_pkg::entry_t wr_data_i
);
  import mspt_pkg::*;

  entry_t               mem_q [STREAMS];
  logic [STREAMS-1:0]   vld_q;
  entry_t               rd_q;
  logic                 rd_vld_q;

  // an entry never written reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// File: hw/rtl/multi_stream_period_timer_core.sv
// Period timer for a table of audio streams.
// Input channel in_i carries one command item: prepare, start, stop, tick or
// position query. Output channel out_o carries period-elapsed events and
// query replies; the final result caused by an item has last set.
// cfg_we_i/cfg_wdata_i write the tick rate; write it only while idle.
// One item is handled at a time; in_i.ready is high only when idle.
// Prepare, start and stop are handled in the idle state. A query of a stream in
// range reads its entry, then waits on the 28-step serial divider before its
// reply. A tick walks the stream memory one entry at a time over its single
// read port: a stopped stream takes a scan state only, a running stream goes
// through scan, read, two reductions and write-back (scan and read only if it
// was never prepared), and each position sum of at least twice its limit goes
// through the divider (a byte rate large against the limit, or a lowered tick rate).
// Results leave through an output register; when the receiver stalls the
// sequencer waits until that register is free, so nothing is dropped.
// Reset clears running flags, stream entries (valid bits) and the output,
// and loads the tick rate with 250.
module multi_stream_period_timer_core #(
  parameter int unsigned STREAMS = mspt_pkg::DefaultStreams
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mspt_pkg::TicksW-1:0] cfg_wdata_i,
  mspt_in_if.sink                     in_i,
  mspt_out_if.source                  out_o
);
  import mspt_pkg::*;

  localparam int unsigned IdxW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

  typedef enum logic [11:0] {
    StIdle = 12'h001,
    StScan = 12'h002,
    StTMul = 12'h004,
    StBRed = 12'h008,
    StBDiv = 12'h010,
    StPRed = 12'h020,
    StPDiv = 12'h040,
    StTWr  = 12'h080,
    StTEnd = 12'h100,
    StQRd  = 12'h200,
    StQDiv = 12'h400,
    StQOut = 12'h800
  } state_e;

  state_e              state_q, state_d;
  logic [TicksW-1:0]   ticks_q, ticks_d;
  logic [TicksW-1:0]   t_q, t_d;
  logic [STREAMS-1:0]  running_q, running_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  entry_t              ent_q, ent_d;
  logic [PosW-1:0]     blim_q, blim_d;
  logic [PosW-1:0]     plim_q, plim_d;
  logic [DivDW-1:0]    bsum_q, bsum_d;
  logic [PosW-1:0]     psum_q, psum_d;
  logic [PosW-1:0]     bnew_q, bnew_d;
  logic [PosW-1:0]     pnew_q, pnew_d;
  logic                wrap_q, wrap_d;
  logic [CntW-1:0]     evcnt_q, evcnt_d;
  logic                pend_vld_q, pend_vld_d;
  logic [StreamW-1:0]  pend_q, pend_d;
  logic [StreamW-1:0]  qs_q, qs_d;
  logic [FramesW-1:0]  qres_q, qres_d;

  logic                out_vld_q, out_vld_d;
  logic [StreamW-1:0]  out_stream_q, out_stream_d;
  logic                out_ev_q, out_ev_d;
  logic [FramesW-1:0]  out_pos_q, out_pos_d;
  logic                out_last_q, out_last_d;

  logic                out_free;
  logic                push;
  logic [StreamW-1:0]  push_stream;
  logic                push_ev;
  logic [FramesW-1:0]  push_pos;
  logic                push_last;

  logic                mem_re;
  logic [IdxW-1:0]     mem_raddr;
  entry_t              mem_rdata;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  entry_t              mem_wdata;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                in_acc;
  logic                in_range;
  logic [IdxW-1:0]     sidx;
  logic [SizeW-1:0]    prep_bsz;
  logic [SizeW-1:0]    prep_psz;
  logic                prep_ok;
  logic                last_idx;
  logic                emit_ev;
  logic                need_push;
  logic [DivDW-1:0]    qhalf;

  mspt_stream_mem #(
    .STREAMS (STREAMS),
    .IdxW    (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata)
  );

  mspt_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && (state_q == StIdle);
  assign in_range   = {1'b0, in_i.stream} < (StreamW + 1)'(STREAMS);
  assign sidx       = in_i.stream[IdxW-1:0];
  assign prep_bsz   = clamp_size(in_i.buffer_bytes);
  assign prep_psz   = clamp_size(in_i.period_bytes);
  assign prep_ok    = in_range && (in_i.bytes_per_second != '0) &&
                      (prep_bsz != '0) && (prep_psz != '0);
  assign last_idx   = (idx_q == IdxW'(STREAMS - 1));
  assign out_free   = !out_vld_q || out_o.ready;
  assign emit_ev    = wrap_q && (evcnt_q < CntW'(MaxResults));
  // an earlier event can only be sent once we know it is not the last one
  assign need_push  = emit_ev && pend_vld_q;
  assign qhalf      = div_rsp.quotient >> 1;

  always_comb begin
    state_d    = state_q;
    ticks_d    = ticks_q;
    t_d        = t_q;
    running_d  = running_q;
    idx_d      = idx_q;
    ent_d      = ent_q;
    blim_d     = blim_q;
    plim_d     = plim_q;
    bsum_d     = bsum_q;
    psum_d     = psum_q;
    bnew_d     = bnew_q;
    pnew_d     = pnew_q;
    wrap_d     = wrap_q;
    evcnt_d    = evcnt_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    qs_d       = qs_q;
    qres_d     = qres_q;

    push        = 1'b0;
    push_stream = '0;
    push_ev     = 1'b0;
    push_pos    = '0;
    push_last   = 1'b0;

    mem_re    = 1'b0;
    mem_raddr = idx_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = ent_q;

    div_req = '0;

    if (cfg_we_i) begin
      ticks_d = cfg_wdata_i;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (kind_e'(in_i.kind))
            KindPrepare: begin
              mem_we             = prep_ok;
              mem_waddr          = sidx;
              mem_wdata.rate     = in_i.bytes_per_second;
              mem_wdata.buf_size = prep_bsz;
              mem_wdata.per_size = prep_psz;
              mem_wdata.ppos     = '0;
              mem_wdata.bpos     = '0;
            end
            KindStart, KindStop: begin
              if (in_range) begin
                running_d[sidx] = (kind_e'(in_i.kind) == KindStart);
              end
            end
            KindTick: begin
              t_d        = eff_ticks(ticks_q);
              idx_d      = '0;
              evcnt_d    = '0;
              pend_vld_d = 1'b0;
              state_d    = StScan;
            end
            KindQuery: begin
              t_d  = eff_ticks(ticks_q);
              qs_d = in_i.stream;
              if (in_range) begin
                mem_re    = 1'b1;
                mem_raddr = sidx;
                state_d   = StQRd;
              end else begin
                qres_d  = '0;
                state_d = StQOut;
              end
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (running_q[idx_q]) begin
          mem_re  = 1'b1;
          state_d = StTMul;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = last_idx ? StTEnd : StScan;
        end
      end
      StTMul: begin
        if ((mem_rdata.buf_size == '0) || (mem_rdata.per_size == '0)) begin
          idx_d   = idx_q + IdxW'(1);
          state_d = last_idx ? StTEnd : StScan;
        end else begin
          ent_d   = mem_rdata;
          blim_d  = PosW'(mem_rdata.buf_size) * PosW'(t_q);
          plim_d  = PosW'(mem_rdata.per_size) * PosW'(t_q);
          bsum_d  = {1'b0, mem_rdata.bpos} + DivDW'(mem_rdata.rate);
          psum_d  = mem_rdata.ppos + PosW'(mem_rdata.rate);
          state_d = StBRed;
        end
      end
      StBRed: begin
        if (bsum_q < {1'b0, blim_q}) begin
          bnew_d  = bsum_q[PosW-1:0];
          state_d = StPRed;
        end else if (bsum_q < {blim_q, 1'b0}) begin
          bnew_d  = PosW'(bsum_q - {1'b0, blim_q});
          state_d = StPRed;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = bsum_q;
          div_req.divisor  = blim_q;
          state_d          = StBDiv;
        end
      end
      StBDiv: begin
        if (div_rsp.done) begin
          bnew_d  = div_rsp.remainder;
          state_d = StPRed;
        end
      end
      StPRed: begin
        if ({1'b0, psum_q} < {1'b0, plim_q}) begin
          pnew_d  = psum_q;
          wrap_d  = 1'b0;
          state_d = StTWr;
        end else begin
          wrap_d = 1'b1;
          if ({1'b0, psum_q} < {plim_q, 1'b0}) begin
            pnew_d  = psum_q - plim_q;
            state_d = StTWr;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, psum_q};
            div_req.divisor  = plim_q;
            state_d          = StPDiv;
          end
        end
      end
      StPDiv: begin
        if (div_rsp.done) begin
          pnew_d  = div_rsp.remainder;
          state_d = StTWr;
        end
      end
      StTWr: begin
        if (!need_push || out_free) begin
          mem_we         = 1'b1;
          mem_wdata.ppos = pnew_q;
          mem_wdata.bpos = bnew_q;
          if (need_push) begin
            push        = 1'b1;
            push_stream = pend_q;
            push_ev     = 1'b1;
          end
          if (emit_ev) begin
            pend_vld_d = 1'b1;
            pend_d     = StreamW'(idx_q);
            evcnt_d    = evcnt_q + CntW'(1);
          end
          idx_d   = idx_q + IdxW'(1);
          state_d = last_idx ? StTEnd : StScan;
        end
      end
      StTEnd: begin
        if (!pend_vld_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          push        = 1'b1;
          push_stream = pend_q;
          push_ev     = 1'b1;
          push_last   = 1'b1;
          pend_vld_d  = 1'b0;
          state_d     = StIdle;
        end
      end
      StQRd: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, mem_rdata.bpos};
        div_req.divisor  = PosW'(t_q);
        state_d          = StQDiv;
      end
      StQDiv: begin
        if (div_rsp.done) begin
          qres_d  = (qhalf > DivDW'(FramesMax)) ? FramesMax : qhalf[FramesW-1:0];
          state_d = StQOut;
        end
      end
      StQOut: begin
        if (out_free) begin
          push        = 1'b1;
          push_stream = qs_q;
          push_pos    = qres_q;
          push_last   = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_vld_d    = out_vld_q;
    out_stream_d = out_stream_q;
    out_ev_d     = out_ev_q;
    out_pos_d    = out_pos_q;
    out_last_d   = out_last_q;
    if (push) begin
      out_vld_d    = 1'b1;
      out_stream_d = push_stream;
      out_ev_d     = push_ev;
      out_pos_d    = push_pos;
      out_last_d   = push_last;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      ticks_q    <= TicksReset;
      running_q  <= '0;
      idx_q      <= '0;
      evcnt_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ticks_q    <= ticks_d;
      running_q  <= running_d;
      idx_q      <= idx_d;
      evcnt_q    <= evcnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q          <= t_d;
    ent_q        <= ent_d;
    blim_q       <= blim_d;
    plim_q       <= plim_d;
    bsum_q       <= bsum_d;
    psum_q       <= psum_d;
    bnew_q       <= bnew_d;
    pnew_q       <= pnew_d;
    wrap_q       <= wrap_d;
    pend_q       <= pend_d;
    qs_q         <= qs_d;
    qres_q       <= qres_d;
    out_stream_q <= out_stream_d;
    out_ev_q     <= out_ev_d;
    out_pos_q    <= out_pos_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.stream_out      = out_stream_q;
  assign out_o.is_period_event = out_ev_q;
  assign out_o.position_frames = out_pos_q;
  assign out_o.last            = out_last_q;

endmodule
